>>> rtl/core/assert_macros.svh
// assertion macros for the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/kglf_pkg.sv
package kglf_pkg;
    localparam int MAX_GAP = 63;
    localparam int GAP_W = 6;
    localparam int POS_W = 32;
    localparam int MAG_W = 33;
    localparam int PROD_W = MAG_W + GAP_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W = 6;

    typedef logic [GAP_W-1:0] t_gap;
    typedef logic [POS_W-1:0] t_pos;
endpackage

>>> rtl/core/kglf_div.sv
module kglf_div
    import kglf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PROD_W-1:0]   i_num,
    input  logic [GAP_W:0]      i_den,
    output logic                o_done,
    output logic [PROD_W-1:0]   o_quo
);
    // restoring divider, one quotient bit per cycle
    logic [PROD_W-1:0] r_num, n_num;
    logic [GAP_W+1:0]  r_rem, n_rem;
    logic [GAP_W:0]    r_den;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy, r_done, n_done;
    logic [GAP_W+1:0]  w_trial;

    always_comb begin
        w_trial = {r_rem[GAP_W:0], r_num[PROD_W-1]};
        n_num = r_num;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num = i_num;
            n_rem = '0;
            n_cnt = STEP_W'(DIV_STEPS - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_num = {r_num[PROD_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_num = {r_num[PROD_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quo = r_num;
endmodule

>>> rtl/core/keyframe_gap_lerp_fill.sv
// keyframe_gap_lerp_fill: fills the empty frames of a position track
// input channel i_valid/o_ready carries one frame per word: has_key,
// key_x/y/z (signed Q16.16) and track_end
// output channel o_valid/i_ready carries one position word per released frame
// an empty frame without track_end is counted and gives no output; the input
// is ready again on the next cycle
// a key frame releases the pending frames, each interpolated per axis by a
// shared multiplier and a serial divider, then the key itself
// a key with no pending frames goes through the emit state to the output state
// without a previous key, or at a track end without a key, pending frames are
// copies; each word passes through the emit and output states
// the input is not ready while a frame is being worked off
// a stalled receiver holds the output word and freezes the sequencer
// synchronous active-low reset clears the track state: no previous key,
// empty gap
module keyframe_gap_lerp_fill
    import kglf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_has_key,
    input  logic [31:0] i_key_x,
    input  logic [31:0] i_key_y,
    input  logic [31:0] i_key_z,
    input  logic        i_track_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pos_x,
    output logic [31:0] o_pos_y,
    output logic [31:0] o_pos_z,
    output logic        o_was_filled,
    output logic        o_gap_overflow,
    output logic        o_run_last
);
`include "assert_macros.svh"

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_DIV  = 6'b000100,
        S_WAIT = 6'b001000,
        S_EMIT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_pos   r_prev [3];
    t_pos   r_key  [3];
    t_pos   r_res  [3];
    logic   r_have_prev, r_dropped, r_end, r_keyf;
    t_gap   r_gap, r_idx;
    logic [1:0] r_ax;
    logic [MAG_W-1:0] r_mag;
    logic   r_neg;
    logic [PROD_W-1:0] r_prod;
    logic   r_start;
    logic   w_done;
    logic [PROD_W-1:0] w_quo;
    logic   r_ov, r_filled, r_last;

    logic signed [MAG_W-1:0] w_diff;
    logic [PROD_W-1:0] w_num;
    logic [GAP_W:0] w_den;
    logic signed [MAG_W-1:0] w_sum;
    logic w_in_acc, w_out_acc;

    assign w_in_acc = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    assign w_diff = $signed({r_key[r_ax][31], r_key[r_ax]})
                  - $signed({r_prev[r_ax][31], r_prev[r_ax]});
    assign w_den = {1'b0, r_gap} + 1'b1;
    assign w_num = r_prod + PROD_W'(w_den >> 1);
    assign w_sum = r_neg
        ? $signed({r_prev[r_ax][31], r_prev[r_ax]}) - $signed(w_quo[MAG_W-1:0])
        : $signed({r_prev[r_ax][31], r_prev[r_ax]}) + $signed(w_quo[MAG_W-1:0]);

    kglf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have_prev <= 1'b0;
            r_gap <= '0;
            r_dropped <= 1'b0;
            r_start <= 1'b0;
            for (int k = 0; k < 3; k++) r_prev[k] <= '0;
        end else begin
            r_start <= (r_state == S_DIV);
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_key[0] <= i_key_x;
                        r_key[1] <= i_key_y;
                        r_key[2] <= i_key_z;
                        r_end <= i_track_end;
                        r_keyf <= i_has_key;
                        r_idx <= GAP_W'(1);
                        r_ax <= 2'd0;
                        if (!i_has_key) begin
                            if (r_gap < t_gap'(MAX_GAP)) r_gap <= r_gap + 1'b1;
                            else r_dropped <= 1'b1;
                            if (i_track_end) r_state <= S_EMIT;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    // decide next word of this frame
                    r_ov <= r_dropped;
                    if (r_keyf && r_idx == r_gap + 1'b1 || r_keyf && r_gap == '0) begin
                        r_res <= r_key;
                        r_filled <= 1'b0;
                        r_last <= 1'b1;
                        r_state <= S_OUT;
                    end else if (!r_keyf) begin
                        for (int k = 0; k < 3; k++)
                            r_res[k] <= r_have_prev ? r_prev[k] : '0;
                        r_filled <= 1'b1;
                        r_last <= (r_idx == r_gap);
                        r_state <= S_OUT;
                    end else if (!r_have_prev) begin
                        r_res <= r_key;
                        r_filled <= 1'b1;
                        r_last <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_ax <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_neg <= w_diff < 0;
                    r_mag <= (w_diff < 0) ? MAG_W'(-w_diff) : MAG_W'(w_diff);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_prod <= {{GAP_W{1'b0}}, r_mag} * r_idx;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_res[r_ax] <= w_sum[31:0];
                        if (r_ax == 2'd2) begin
                            r_filled <= 1'b1;
                            r_last <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_ax <= r_ax + 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_acc) begin
                        if (r_last) begin
                            r_state <= S_IDLE;
                            if (r_end) begin
                                for (int k = 0; k < 3; k++) r_prev[k] <= '0;
                                r_have_prev <= 1'b0;
                            end else if (r_keyf) begin
                                r_prev <= r_key;
                                r_have_prev <= 1'b1;
                            end
                            r_gap <= '0;
                            r_dropped <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_state <= S_EMIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pos_x = r_res[0];
    assign o_pos_y = r_res[1];
    assign o_pos_z = r_res[2];
    assign o_was_filled = r_filled;
    assign o_gap_overflow = r_ov;
    assign o_run_last = r_last;

    `ASSERT_IMPLIES(a_ready_idle, i_clk, i_rst_n, o_ready, !o_valid)
    `ASSERT_IMPLIES(a_key_last, i_clk, i_rst_n, o_valid && !o_was_filled, o_run_last)
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_valid && i_ready && o_run_last, o_ready)
endmodule
